// ===== rtl/core/serial_frame_parser_defines.svh =====
// Assertion macros for the serial frame parser checker.
`ifndef SERIAL_FRAME_PARSER_DEFINES_SVH
`define SERIAL_FRAME_PARSER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SFP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `SFP_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ===== rtl/core/sfp_pkg.sv =====
// Shared types, constants and the CRC step for the serial frame parser.
`default_nettype none

package sfp_pkg;

   localparam int DEFAULT_MAX_PAYLOAD = 64;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_ADDR_W          = 3;

   localparam logic [31:0] TIMEOUT_RESET = 32'd100000;
   localparam logic [7:0]  VERSION_RESET = 8'd1;

   localparam logic CSR_IDX_TIMEOUT = 1'b0;
   localparam logic CSR_IDX_VERSION = 1'b1;

   localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;

   localparam logic [6:0] HEADER_BYTES  = 7'd9;
   localparam logic [6:0] TRAILER_BYTES = 7'd2;

   // Byte positions inside the header.
   localparam logic [6:0] HDR_MARK_FIRST  = 7'd0;
   localparam logic [6:0] HDR_MARK_SECOND = 7'd1;
   localparam logic [6:0] HDR_VERSION     = 7'd2;
   localparam logic [6:0] HDR_TYPE        = 7'd3;
   localparam logic [6:0] HDR_FLAGS       = 7'd4;
   localparam logic [6:0] HDR_SEQ_LO      = 7'd5;
   localparam logic [6:0] HDR_SEQ_HI      = 7'd6;
   localparam logic [6:0] HDR_LEN_LO      = 7'd7;

   typedef enum logic [2:0] {
      STATUS_INCOMPLETE = 3'd0,
      STATUS_FRAME      = 3'd1,
      STATUS_TIMEOUT    = 3'd2,
      STATUS_MALFORMED  = 3'd3,
      STATUS_BAD_CRC    = 3'd4
   } sfp_status_type;

   // One classified byte, handed from the parser to the result sequencer.
   typedef struct packed {
      sfp_status_type status;
      logic [7:0]     message_type;
      logic [7:0]     flags;
      logic [15:0]    sequence_num;
      logic [6:0]     length;
   } sfp_job_type;

   // CRC-16/CCITT-FALSE over one byte, MSB first.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfp_front.sv =====
// Byte parser: timeout check, marker hunt, header capture, CRC and payload write.
`default_nettype none

module sfp_front #(
   parameter int MAX_PAYLOAD = sfp_pkg::DEFAULT_MAX_PAYLOAD,
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
   localparam int OW = $clog2(sfp_pkg::QUEUE_DEPTH + 2)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic [63:0]         req_arrival_time,
   input  wire logic [31:0]         cfg_timeout_us,
   input  wire logic [7:0]          cfg_protocol_version,
   output logic                     job_push,
   input  wire logic                job_ready,
   output sfp_pkg::sfp_job_type     job_data,
   output logic                     mem_wr_en,
   output logic [AW-1:0]            mem_wr_addr,
   output logic [7:0]               mem_wr_data,
   input  wire logic                frame_done
);

   logic          busy_ff, busy_in;
   logic [7:0]    byte_ff;
   logic [63:0]   time_ff;
   logic [6:0]    count_ff, count_in;
   logic [6:0]    frame_len_ff, frame_len_in;
   logic [63:0]   last_time_ff, last_time_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    version_ff, version_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    flags_ff, flags_in;
   logic [15:0]   seq_ff, seq_in;
   logic [6:0]    len_ff, len_in;
   logic [7:0]    crc_lo_ff, crc_lo_in;
   logic [OW-1:0] pending_ff, pending_in;

   logic [63:0]   gap;
   logic          late;
   logic [6:0]    count_next;
   logic [7:0]    payload_end;
   logic          is_payload;
   logic          fire;
   logic          restart;
   sfp_pkg::sfp_status_type st;

   assign req_ready = !busy_ff;

   assign gap         = time_ff - last_time_ff;
   assign late        = (count_ff != 7'd0)
                        && ((|gap[63:32]) || (gap[31:0] > cfg_timeout_us));
   assign count_next  = count_ff + 7'd1;
   assign payload_end = {1'b0, sfp_pkg::HEADER_BYTES} + {1'b0, len_ff};
   assign is_payload  = !late && (count_ff >= sfp_pkg::HEADER_BYTES)
                        && ({1'b0, count_ff} < payload_end);
   // Hold a payload byte while an earlier frame still replays from the store.
   assign fire        = busy_ff && job_ready && !(is_payload && (pending_ff != '0));

   assign mem_wr_en   = fire && is_payload;
   assign mem_wr_addr = AW'(count_ff - sfp_pkg::HEADER_BYTES);
   assign mem_wr_data = byte_ff;

   assign job_push              = fire;
   assign job_data.status       = st;
   assign job_data.message_type = type_ff;
   assign job_data.flags        = flags_ff;
   assign job_data.sequence_num = seq_ff;
   assign job_data.length       = len_ff;

   always_comb begin
      busy_in      = busy_ff;
      count_in     = count_ff;
      frame_len_in = frame_len_ff;
      last_time_in = last_time_ff;
      crc_in       = crc_ff;
      version_in   = version_ff;
      type_in      = type_ff;
      flags_in     = flags_ff;
      seq_in       = seq_ff;
      len_in       = len_ff;
      crc_lo_in    = crc_lo_ff;
      restart      = 1'b0;
      st           = sfp_pkg::STATUS_INCOMPLETE;

      if (req_valid && !busy_ff) begin
         busy_in = 1'b1;
      end

      if (fire) begin
         busy_in = 1'b0;
         if (late) begin
            restart = 1'b1;
            st      = sfp_pkg::STATUS_TIMEOUT;
         end else begin
            last_time_in = time_ff;
            if (count_ff == sfp_pkg::HDR_MARK_FIRST) begin
               if (byte_ff == sfp_pkg::SYNC_FIRST) begin
                  count_in = sfp_pkg::HDR_MARK_SECOND;
               end
            end else if (count_ff == sfp_pkg::HDR_MARK_SECOND) begin
               if (byte_ff == sfp_pkg::SYNC_SECOND) begin
                  count_in = sfp_pkg::HDR_VERSION;
               end else if (byte_ff == sfp_pkg::SYNC_FIRST) begin
                  count_in = sfp_pkg::HDR_MARK_SECOND;
               end else begin
                  count_in = sfp_pkg::HDR_MARK_FIRST;
               end
            end else if (count_ff < sfp_pkg::HEADER_BYTES) begin
               crc_in   = sfp_pkg::crc_step(crc_ff, byte_ff);
               count_in = count_next;
               case (count_ff)
                  sfp_pkg::HDR_VERSION: begin
                     version_in = byte_ff;
                  end
                  sfp_pkg::HDR_TYPE: begin
                     type_in = byte_ff;
                  end
                  sfp_pkg::HDR_FLAGS: begin
                     flags_in = byte_ff;
                  end
                  sfp_pkg::HDR_SEQ_LO: begin
                     seq_in = {seq_ff[15:8], byte_ff};
                  end
                  sfp_pkg::HDR_SEQ_HI: begin
                     seq_in = {byte_ff, seq_ff[7:0]};
                  end
                  sfp_pkg::HDR_LEN_LO: begin
                     // saturate the low length byte at seven bits
                     len_in = byte_ff[7] ? 7'h7F : byte_ff[6:0];
                  end
                  default: begin
                     // high length byte
                     if ((byte_ff != 8'd0) || (len_ff > 7'(MAX_PAYLOAD))) begin
                        restart = 1'b1;
                        st      = sfp_pkg::STATUS_MALFORMED;
                     end else begin
                        frame_len_in = sfp_pkg::HEADER_BYTES + sfp_pkg::TRAILER_BYTES
                                       + len_ff;
                     end
                  end
               endcase
            end else if (is_payload) begin
               crc_in   = sfp_pkg::crc_step(crc_ff, byte_ff);
               count_in = count_next;
            end else if (count_next != frame_len_ff) begin
               crc_lo_in = byte_ff;
               count_in  = count_next;
            end else begin
               restart = 1'b1;
               if ({byte_ff, crc_lo_ff} != crc_ff) begin
                  st = sfp_pkg::STATUS_BAD_CRC;
               end else if (version_ff != cfg_protocol_version) begin
                  st = sfp_pkg::STATUS_MALFORMED;
               end else begin
                  st = sfp_pkg::STATUS_FRAME;
               end
            end
         end
      end

      if (restart) begin
         count_in     = '0;
         frame_len_in = '0;
         last_time_in = '0;
         crc_in       = sfp_pkg::CRC_INIT;
      end

      pending_in = pending_ff;
      if (fire && (st == sfp_pkg::STATUS_FRAME) && !frame_done) begin
         pending_in = pending_ff + OW'(1);
      end else if (frame_done && !(fire && (st == sfp_pkg::STATUS_FRAME))) begin
         pending_in = pending_ff - OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !busy_ff) begin
         byte_ff <= req_data_byte;
         time_ff <= req_arrival_time;
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         frame_len_ff <= '0;
         last_time_ff <= '0;
         crc_ff       <= sfp_pkg::CRC_INIT;
         version_ff   <= '0;
         type_ff      <= '0;
         flags_ff     <= '0;
         seq_ff       <= '0;
         len_ff       <= '0;
         crc_lo_ff    <= '0;
         pending_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         frame_len_ff <= frame_len_in;
         last_time_ff <= last_time_in;
         crc_ff       <= crc_in;
         version_ff   <= version_in;
         type_ff      <= type_in;
         flags_ff     <= flags_in;
         seq_ff       <= seq_in;
         len_ff       <= len_in;
         crc_lo_ff    <= crc_lo_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sfp_queue.sv =====
// Short job queue between the byte parser and the result sequencer.
`default_nettype none

module sfp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  sfp_pkg::sfp_job_type      push_data,
   output logic                      push_ready,
   input  wire logic                 pop,
   output logic                      pop_valid,
   output sfp_pkg::sfp_job_type      pop_data
);

   localparam int DEPTH = sfp_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   sfp_pkg::sfp_job_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != CW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sfp_back.sv =====
// Result sequencer: payload store and replay of jobs as result transactions.
`default_nettype none

module sfp_back #(
   parameter int MAX_PAYLOAD = sfp_pkg::DEFAULT_MAX_PAYLOAD,
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                job_valid,
   output logic                     job_pop,
   input  sfp_pkg::sfp_job_type     job_data,
   input  wire logic                mem_wr_en,
   input  wire logic [AW-1:0]       mem_wr_addr,
   input  wire logic [7:0]          mem_wr_data,
   output logic                     frame_done,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [7:0]               rsp_message_type,
   output logic [7:0]               rsp_flags,
   output logic [15:0]              rsp_sequence_res,
   output logic [6:0]               rsp_payload_length,
   output logic [7:0]               rsp_payload_byte,
   output logic [5:0]               rsp_payload_index,
   output logic                     rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_SEND
   } state_type;

   logic [7:0] payload_mem [MAX_PAYLOAD];
   logic [7:0] rd_data_ff;

   state_type            state_ff, state_in;
   sfp_pkg::sfp_job_type job_ff, job_in;
   logic [5:0]           idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [2:0]           status_ff, status_in;
   logic [7:0]           type_ff, type_in;
   logic [7:0]           flags_ff, flags_in;
   logic [15:0]          seq_ff, seq_in;
   logic [6:0]           length_ff, length_in;
   logic [7:0]           pbyte_ff, pbyte_in;
   logic [5:0]           pindex_ff, pindex_in;
   logic                 last_ff, last_in;

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_message_type   = type_ff;
   assign rsp_flags          = flags_ff;
   assign rsp_sequence_res   = seq_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_payload_byte   = pbyte_ff;
   assign rsp_payload_index  = pindex_ff;
   assign rsp_last           = last_ff;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         payload_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= payload_mem[idx_ff[AW-1:0]];
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      idx_in     = idx_ff;
      valid_in   = valid_ff;
      status_in  = status_ff;
      type_in    = type_ff;
      flags_in   = flags_ff;
      seq_in     = seq_ff;
      length_in  = length_ff;
      pbyte_in   = pbyte_ff;
      pindex_in  = pindex_ff;
      last_in    = last_ff;
      job_pop    = 1'b0;
      frame_done = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in  = job_data;
               idx_in  = '0;
               if ((job_data.status == sfp_pkg::STATUS_FRAME) && (job_data.length != '0)) begin
                  state_in = ST_FETCH;
               end else begin
                  // single result: a status, or a frame with an empty payload
                  valid_in  = 1'b1;
                  status_in = job_data.status;
                  pbyte_in  = '0;
                  pindex_in = '0;
                  last_in   = 1'b1;
                  if (job_data.status == sfp_pkg::STATUS_FRAME) begin
                     type_in   = job_data.message_type;
                     flags_in  = job_data.flags;
                     seq_in    = job_data.sequence_num;
                     length_in = job_data.length;
                  end else begin
                     type_in   = '0;
                     flags_in  = '0;
                     seq_in    = '0;
                     length_in = '0;
                  end
                  state_in = ST_SEND;
               end
            end
         end
         ST_FETCH: begin
            // wait for the registered store read
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            valid_in  = 1'b1;
            status_in = job_ff.status;
            type_in   = job_ff.message_type;
            flags_in  = job_ff.flags;
            seq_in    = job_ff.sequence_num;
            length_in = job_ff.length;
            pbyte_in  = rd_data_ff;
            pindex_in = idx_ff;
            last_in   = (({1'b0, idx_ff} + 7'd1) == job_ff.length);
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  frame_done = (job_ff.status == sfp_pkg::STATUS_FRAME);
                  state_in   = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 6'd1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      type_ff   <= type_in;
      flags_ff  <= flags_in;
      seq_ff    <= seq_in;
      length_ff <= length_in;
      pbyte_ff  <= pbyte_in;
      pindex_ff <= pindex_in;
      last_ff   <= last_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/serial_frame_parser.sv =====
// Top level of the serial frame parser: register port, parser, job queue, sequencer.
`default_nettype none

// Serial frame parser. Takes one received byte per request transaction with
// its arrival time in microseconds, hunts for the A5 5A markers, collects the
// nine-byte header, payload and little-endian CRC-16/CCITT-FALSE, and answers
// every byte with at least one response transaction. A good frame answers its
// final CRC byte with one transaction per payload byte (or one with an empty
// payload); every other byte answers with a single status transaction
// (incomplete, timeout, malformed, invalid crc). The parser first captures a
// byte, then checks the gap, advances the header state, folds the byte into
// the CRC and hands a job to a two-entry queue, waiting while it is full. The
// sequencer turns a status job into a response in the cycle after it leaves
// the queue and replays a frame from the payload store one byte at a time
// (address, registered store read, output load), holding each response until
// the consumer raises rsp_ready. The parser keeps accepting while responses
// wait, but holds a payload byte of a new frame until the previous frame has
// been fully replayed, since both share the one payload store. The store
// needs no clearing after reset. Registers: timeout_us at byte address 0,
// protocol_version at byte address 4; write them only while the block is idle.
module serial_frame_parser #(
   parameter int MAX_PAYLOAD = sfp_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic [63:0]                   req_arrival_time,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [7:0]                         rsp_message_type,
   output logic [7:0]                         rsp_flags,
   output logic [15:0]                        rsp_sequence_res,
   output logic [6:0]                         rsp_payload_length,
   output logic [7:0]                         rsp_payload_byte,
   output logic [5:0]                         rsp_payload_index,
   output logic                               rsp_last,
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [sfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [31:0] timeout_us_ff, timeout_us_in;
   logic [7:0]  version_ff, version_in;
   logic        csr_write;
   logic        csr_index;

   logic                 job_push;
   logic                 job_push_ready;
   sfp_pkg::sfp_job_type job_push_data;
   logic                 job_pop;
   logic                 job_pop_valid;
   sfp_pkg::sfp_job_type job_pop_data;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [7:0]           mem_wr_data;
   logic                 frame_done;

   // The port has no wait states; the register index is the word address.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[sfp_pkg::CSR_ADDR_W-1];

   always_comb begin
      timeout_us_in = timeout_us_ff;
      version_in    = version_ff;
      if (csr_write) begin
         case (csr_index)
            sfp_pkg::CSR_IDX_TIMEOUT: begin
               timeout_us_in = csr_pwdata;
            end
            sfp_pkg::CSR_IDX_VERSION: begin
               version_in = csr_pwdata[7:0];
            end
            default: begin
               timeout_us_in = timeout_us_ff;
            end
         endcase
      end
   end

   // Read back the addressed register.
   always_comb begin
      case (csr_index)
         sfp_pkg::CSR_IDX_TIMEOUT: begin
            csr_prdata = timeout_us_ff;
         end
         sfp_pkg::CSR_IDX_VERSION: begin
            csr_prdata = {24'd0, version_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_us_ff <= sfp_pkg::TIMEOUT_RESET;
         version_ff    <= sfp_pkg::VERSION_RESET;
      end else begin
         timeout_us_ff <= timeout_us_in;
         version_ff    <= version_in;
      end
   end

   // Front: classify each byte and write payload bytes into the store.
   sfp_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_arrival_time     (req_arrival_time),
      .cfg_timeout_us       (timeout_us_ff),
      .cfg_protocol_version (version_ff),
      .job_push             (job_push),
      .job_ready            (job_push_ready),
      .job_data             (job_push_data),
      .mem_wr_en            (mem_wr_en),
      .mem_wr_addr          (mem_wr_addr),
      .mem_wr_data          (mem_wr_data),
      .frame_done           (frame_done)
   );

   // Decouple parsing from response back-pressure.
   sfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_push_data),
      .push_ready (job_push_ready),
      .pop        (job_pop),
      .pop_valid  (job_pop_valid),
      .pop_data   (job_pop_data)
   );

   // Back: hold the payload store and emit response transactions.
   sfp_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_pop_valid),
      .job_pop            (job_pop),
      .job_data           (job_pop_data),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .frame_done         (frame_done),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_message_type   (rsp_message_type),
      .rsp_flags          (rsp_flags),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/sfp_checker.sv =====
// Port-level checks for the serial frame parser and their bind.
`default_nettype none
`include "serial_frame_parser_defines.svh"

module sfp_checker #(
   parameter int MAX_PAYLOAD = sfp_pkg::DEFAULT_MAX_PAYLOAD
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [7:0]  rsp_message_type,
   input wire logic [7:0]  rsp_flags,
   input wire logic [15:0] rsp_sequence_res,
   input wire logic [6:0]  rsp_payload_length,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic [5:0]  rsp_payload_index,
   input wire logic        rsp_last
);

   logic is_frame;

   assign is_frame = rsp_valid && (rsp_status == sfp_pkg::STATUS_FRAME);

   `SFP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_payload_byte) && $stable(rsp_payload_index) && $stable(rsp_last), "response changed while stalled")
   `SFP_ASSERT(a_status_only, clock, reset, rsp_valid && !is_frame |-> rsp_last && rsp_message_type == 8'd0 && rsp_flags == 8'd0 && rsp_sequence_res == 16'd0 && rsp_payload_length == 7'd0 && rsp_payload_byte == 8'd0 && rsp_payload_index == 6'd0, "status response carries frame data")
   `SFP_ASSERT(a_last_index, clock, reset, is_frame && rsp_payload_length != 7'd0 |-> {1'b0, rsp_payload_index} < rsp_payload_length && (rsp_last == (({1'b0, rsp_payload_index} + 7'd1) == rsp_payload_length)), "payload index and last disagree")
   `SFP_ASSERT(a_empty_frame, clock, reset, is_frame && rsp_payload_length == 7'd0 |-> rsp_last && rsp_payload_byte == 8'd0 && rsp_payload_index == 6'd0, "empty frame response malformed")
   `SFP_ASSERT_NEVER(a_length_max, clock, reset, is_frame && rsp_payload_length > 7'(MAX_PAYLOAD), "frame length above maximum")

endmodule

bind serial_frame_parser sfp_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (.*);

`default_nettype wire

// ===== test/serial_frame_parser_checker.sv =====
// Response checker for the serial frame parser: predicts results per byte and compares.
`timescale 1ns / 100ps

package sfp_test_pkg;

   // One expected response transaction, field by field.
   typedef struct packed {
      sfp_pkg::sfp_status_type status;
      logic [7:0]              message_type;
      logic [7:0]              flags;
      logic [15:0]             sequence_res;
      logic [6:0]              payload_length;
      logic [7:0]              payload_byte;
      logic [5:0]              payload_index;
      logic                    last;
   } parsed_result_t;

   localparam logic [sfp_pkg::CSR_ADDR_W-1:0] REG_ADDR_TIMEOUT = {sfp_pkg::CSR_IDX_TIMEOUT, 2'b00};
   localparam logic [sfp_pkg::CSR_ADDR_W-1:0] REG_ADDR_VERSION = {sfp_pkg::CSR_IDX_VERSION, 2'b00};

   // CRC-16/CCITT-FALSE, one data bit at a time, MSB first.
   function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] r;
      int k;
      r = crc;
      for (k = 0; k < 8; k++) begin
         if (r[15] ^ data[7-k]) begin
            r = {r[14:0], 1'b0} ^ sfp_pkg::CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

module serial_frame_parser_checker #(
   parameter int MAX_PAYLOAD = sfp_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic [63:0]                     req_arrival_time,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [2:0]                      rsp_status,
   input  logic [7:0]                      rsp_message_type,
   input  logic [7:0]                      rsp_flags,
   input  logic [15:0]                     rsp_sequence_res,
   input  logic [6:0]                      rsp_payload_length,
   input  logic [7:0]                      rsp_payload_byte,
   input  logic [5:0]                      rsp_payload_index,
   input  logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sfp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   input  logic                            csr_pready,
   output int                              mismatch_count,
   output int                              awaited_count
);

   import sfp_pkg::*;
   import sfp_test_pkg::*;

   logic [31:0]    timeout_limit;
   logic [7:0]     wanted_version;
   logic [6:0]     frame_pos;
   logic [6:0]     frame_end;
   logic [63:0]    last_seen_time;
   logic [15:0]    crc_acc;
   logic [7:0]     hdr_version;
   logic [7:0]     hdr_type;
   logic [7:0]     hdr_flags;
   logic [15:0]    hdr_sequence;
   logic [6:0]     hdr_length;
   logic [7:0]     crc_low_seen;
   logic [7:0]     payload_copy [64];
   parsed_result_t parsed_results [$];

   task automatic restart_hunt();
      frame_pos      = '0;
      frame_end      = '0;
      last_seen_time = '0;
      crc_acc        = CRC_INIT;
   endtask

   task automatic push_status(input sfp_status_type st);
      parsed_result_t r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      parsed_results.push_back(r);
   endtask

   task automatic emit_frame();
      parsed_result_t r;
      int n;
      int cnt;
      int k;
      n   = hdr_length;
      cnt = (n == 0) ? 1 : n;
      for (k = 0; k < cnt; k++) begin
         r                = '0;
         r.status         = STATUS_FRAME;
         r.message_type   = hdr_type;
         r.flags          = hdr_flags;
         r.sequence_res   = hdr_sequence;
         r.payload_length = hdr_length;
         r.payload_byte   = (n == 0) ? 8'h00 : payload_copy[k];
         r.payload_index  = (n == 0) ? 6'd0 : k[5:0];
         r.last           = (k == cnt - 1);
         parsed_results.push_back(r);
      end
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic [63:0] now);
      logic [6:0]  pos;
      logic [15:0] got_crc;
      bit          bad_header;
      bad_header = 1'b0;
      if (frame_pos != 0 && (now - last_seen_time) > {32'd0, timeout_limit}) begin
         restart_hunt();
         push_status(STATUS_TIMEOUT);
      end else begin
         last_seen_time = now;
         if (frame_pos == HDR_MARK_FIRST) begin
            if (b == SYNC_FIRST) frame_pos = HDR_MARK_SECOND;
            push_status(STATUS_INCOMPLETE);
         end else if (frame_pos == HDR_MARK_SECOND) begin
            if (b == SYNC_SECOND) begin
               frame_pos = HDR_VERSION;
            end else if (b == SYNC_FIRST) begin
               frame_pos = HDR_MARK_SECOND;
            end else begin
               frame_pos = HDR_MARK_FIRST;
            end
            push_status(STATUS_INCOMPLETE);
         end else begin
            pos       = frame_pos;
            frame_pos = frame_pos + 7'd1;
            if (pos < HEADER_BYTES) begin
               crc_acc = crc16_ccitt_byte(crc_acc, b);
               case (pos)
                  HDR_VERSION: hdr_version = b;
                  HDR_TYPE:    hdr_type = b;
                  HDR_FLAGS:   hdr_flags = b;
                  HDR_SEQ_LO:  hdr_sequence[7:0] = b;
                  HDR_SEQ_HI:  hdr_sequence[15:8] = b;
                  HDR_LEN_LO:  hdr_length = (b > 8'd127) ? 7'd127 : b[6:0];
                  default: begin
                     // length high byte: anything nonzero or an oversize low byte is malformed
                     if (b != 8'h00 || int'(hdr_length) > MAX_PAYLOAD) begin
                        bad_header = 1'b1;
                     end else begin
                        frame_end = HEADER_BYTES + hdr_length + TRAILER_BYTES;
                     end
                  end
               endcase
               if (bad_header) begin
                  restart_hunt();
                  push_status(STATUS_MALFORMED);
               end else begin
                  push_status(STATUS_INCOMPLETE);
               end
            end else if (int'(pos) < int'(HEADER_BYTES) + int'(hdr_length)) begin
               payload_copy[pos - HEADER_BYTES] = b;
               crc_acc = crc16_ccitt_byte(crc_acc, b);
               push_status(STATUS_INCOMPLETE);
            end else if (frame_pos != frame_end) begin
               crc_low_seen = b;
               push_status(STATUS_INCOMPLETE);
            end else begin
               got_crc = {b, crc_low_seen};
               if (got_crc != crc_acc) begin
                  restart_hunt();
                  push_status(STATUS_BAD_CRC);
               end else if (hdr_version != wanted_version) begin
                  restart_hunt();
                  push_status(STATUS_MALFORMED);
               end else begin
                  restart_hunt();
                  emit_frame();
               end
            end
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_response();
      parsed_result_t e;
      if (parsed_results.size() == 0) begin
         $error("status: response transaction with nothing expected, got %0h", rsp_status);
         mismatch_count++;
      end else begin
         e = parsed_results.pop_front();
         compare_field("status", e.status, rsp_status);
         compare_field("message_type", e.message_type, rsp_message_type);
         compare_field("flags", e.flags, rsp_flags);
         compare_field("sequence_res", e.sequence_res, rsp_sequence_res);
         compare_field("payload_length", e.payload_length, rsp_payload_length);
         compare_field("payload_byte", e.payload_byte, rsp_payload_byte);
         compare_field("payload_index", e.payload_index, rsp_payload_index);
         compare_field("last", e.last, rsp_last);
      end
   endtask

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         timeout_limit  = TIMEOUT_RESET;
         wanted_version = VERSION_RESET;
         hdr_version    = '0;
         hdr_type       = '0;
         hdr_flags      = '0;
         hdr_sequence   = '0;
         hdr_length     = '0;
         crc_low_seen   = '0;
         restart_hunt();
         parsed_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == REG_ADDR_TIMEOUT) begin
               timeout_limit = csr_pwdata;
            end else if (csr_paddr == REG_ADDR_VERSION) begin
               wanted_version = csr_pwdata[7:0];
            end
         end
         if (rsp_valid && rsp_ready) check_response();
         if (req_valid && req_ready) predict_byte(req_data_byte, req_arrival_time);
      end
      awaited_count <= parsed_results.size();
   end

endmodule

// ===== test/serial_frame_parser_test.sv =====
// Testbench top for the serial frame parser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module serial_frame_parser_test;

   import sfp_pkg::*;
   import sfp_test_pkg::*;

   // Kinds of byte sequences the random part is built from.
   typedef enum int {
      SEQ_GOOD,
      SEQ_BAD_CRC,
      SEQ_BAD_VERSION,
      SEQ_OVERSIZE,
      SEQ_LATE_BYTE,
      SEQ_NOISE,
      SEQ_DOUBLE_MARK,
      SEQ_COUNT
   } stim_kind_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_data_byte;
   logic [63:0]            req_arrival_time;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [2:0]             rsp_status;
   logic [7:0]             rsp_message_type;
   logic [7:0]             rsp_flags;
   logic [15:0]            rsp_sequence_res;
   logic [6:0]             rsp_payload_length;
   logic [7:0]             rsp_payload_byte;
   logic [5:0]             rsp_payload_index;
   logic                   rsp_last;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int                     mismatch_count;
   int                     awaited_count;

   // Stimulus shaping state: link clock in microseconds, idle odds, register mirror.
   logic [63:0]            link_time_us;
   int                     send_idle_pct;
   int                     recv_idle_pct;
   int                     bytes_sent;
   int                     seq_total;
   logic [31:0]            cur_timeout;
   logic [7:0]             cur_version;

   serial_frame_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_arrival_time   (req_arrival_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_message_type   (rsp_message_type),
      .rsp_flags          (rsp_flags),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_last           (rsp_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   serial_frame_parser_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_arrival_time   (req_arrival_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_message_type   (rsp_message_type),
      .rsp_flags          (rsp_flags),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_last           (rsp_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatch_count     (mismatch_count),
      .awaited_count      (awaited_count)
   );

   // 2 ns clock period.
   always #1 clock = ~clock;

   // Throttle the response side: drop rsp_ready at the falling edge per the idle odds.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Hard stop in case the block hangs somewhere.
   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   // Write one register through the APB-style port: setup cycle, then access cycle.
   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] timeout_value, input logic [7:0] version_value);
      write_register(REG_ADDR_TIMEOUT, timeout_value);
      write_register(REG_ADDR_VERSION, {24'd0, version_value});
      cur_timeout = timeout_value;
      cur_version = version_value;
   endtask

   // Drop valid, then hold until every expected response has drained plus a margin.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   // Present one byte transaction and hold it until the block takes it.
   task automatic send_byte(input logic [7:0] value, input logic [63:0] stamp);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= value;
      req_arrival_time <= stamp;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Gap inside a frame: never beyond the timeout, sometimes right on it.
   function automatic logic [63:0] in_frame_gap();
      int unsigned span;
      span = (cur_timeout < 50) ? cur_timeout : 50;
      if ($urandom_range(0, 7) == 0) begin
         return {32'd0, cur_timeout};
      end
      return $urandom_range(0, span);
   endfunction

   // Advance the link clock and send; a late byte overshoots the timeout.
   task automatic send_timed(input logic [7:0] value, input bit late);
      if (late) begin
         link_time_us += {32'd0, cur_timeout} + 64'd1 + $urandom_range(0, 1000);
      end else begin
         link_time_us += in_frame_gap();
      end
      send_byte(value, link_time_us);
   endtask

   // Force the parser back to the hunt: jump the clock to a random point past the timeout.
   task automatic resync();
      logic [63:0] stamp;
      stamp = {$urandom, $urandom};
      if (stamp - link_time_us <= {32'd0, cur_timeout}) begin
         stamp = link_time_us + {32'd0, cur_timeout} + 64'd1 + $urandom;
      end
      link_time_us = stamp;
      send_byte(8'($urandom), link_time_us);
   endtask

   // Build a frame with random header content and send it, optionally spoiled.
   task automatic send_frame(input logic [7:0] version_byte, input logic [7:0] len_lo,
                             input logic [7:0] len_hi, input bit spoil_crc,
                             input int late_at, input bit header_only);
      logic [7:0]  frame_bytes [$];
      logic [15:0] crc;
      logic [15:0] seq_num;
      int          i;
      seq_num     = $urandom;
      frame_bytes = {SYNC_FIRST, SYNC_SECOND, version_byte, 8'($urandom), 8'($urandom),
                     seq_num[7:0], seq_num[15:8], len_lo, len_hi};
      if (!header_only) begin
         for (i = 0; i < len_lo; i++) frame_bytes.push_back(8'($urandom));
         // CRC covers the header from the version byte on, then the payload
         crc = CRC_INIT;
         for (i = 2; i < frame_bytes.size(); i++) crc = crc16_ccitt_byte(crc, frame_bytes[i]);
         if (spoil_crc) crc ^= 16'h1 << $urandom_range(0, 15);
         frame_bytes.push_back(crc[7:0]);
         frame_bytes.push_back(crc[15:8]);
      end
      for (i = 0; i < frame_bytes.size(); i++) send_timed(frame_bytes[i], i == late_at);
   endtask

   task automatic run_sequence(input stim_kind_t kind);
      logic [7:0] len;
      logic [7:0] len_hi;
      logic [7:0] noise;
      int         r;
      len = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
      resync();
      case (kind)
         SEQ_GOOD: begin
            send_frame(cur_version, len, 8'd0, 1'b0, -1, 1'b0);
         end
         SEQ_BAD_CRC: begin
            send_frame(cur_version, len, 8'd0, 1'b1, -1, 1'b0);
         end
         SEQ_BAD_VERSION: begin
            send_frame(cur_version ^ (8'h1 << $urandom_range(0, 7)), len, 8'd0, 1'b0, -1, 1'b0);
         end
         SEQ_OVERSIZE: begin
            // either a low length byte past the maximum or a nonzero high byte
            if ($urandom_range(0, 1) == 0) begin
               len    = 8'($urandom_range(MAX_PAYLOAD_T + 1, 255));
               len_hi = 8'd0;
            end else begin
               len    = 8'($urandom);
               len_hi = 8'($urandom_range(1, 255));
            end
            send_frame(cur_version, len, len_hi, 1'b0, -1, 1'b1);
         end
         SEQ_LATE_BYTE: begin
            send_frame(cur_version, len, 8'd0, 1'b0, $urandom_range(1, 10 + len), 1'b0);
         end
         SEQ_NOISE: begin
            repeat ($urandom_range(1, 6)) begin
               r     = $urandom_range(0, 7);
               noise = (r < 2) ? SYNC_FIRST : (r == 2) ? SYNC_SECOND : 8'($urandom);
               send_timed(noise, 1'b0);
            end
         end
         default: begin
            // extra first markers ahead of a good frame
            repeat ($urandom_range(1, 3)) send_timed(SYNC_FIRST, 1'b0);
            send_frame(cur_version, len, 8'd0, 1'b0, -1, 1'b0);
         end
      endcase
   endtask

   function automatic stim_kind_t pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return SEQ_GOOD;
      if (r < 55) return SEQ_BAD_CRC;
      if (r < 63) return SEQ_BAD_VERSION;
      if (r < 71) return SEQ_OVERSIZE;
      if (r < 81) return SEQ_LATE_BYTE;
      if (r < 91) return SEQ_NOISE;
      return SEQ_DOUBLE_MARK;
   endfunction

   localparam int MAX_PAYLOAD_T = DEFAULT_MAX_PAYLOAD;

   // Per-phase register settings and idle odds.
   localparam logic [31:0] PHASE_TIMEOUT [3] = '{32'd30, 32'd0, 32'hFFFF_FFFF};
   localparam logic [7:0]  PHASE_VERSION [3] = '{8'hFF, 8'h00, 8'hA5};
   localparam int          PHASE_SEND_IDLE [3] = '{29, 74, 0};
   localparam int          PHASE_RECV_IDLE [3] = '{74, 29, 0};

   initial begin
      // Drive every input to a known value before the first edge.
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_arrival_time = '0;
      rsp_ready        = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      send_idle_pct    = PHASE_SEND_IDLE[0];
      recv_idle_pct    = PHASE_RECV_IDLE[0];
      bytes_sent       = 0;
      seq_total        = 0;
      cur_timeout      = TIMEOUT_RESET;
      cur_version      = VERSION_RESET;
      // Start just below the wrap so the directed bytes cross zero on the link clock.
      link_time_us     = 64'hFFFF_FFFF_FFFF_FFF8;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: plain noise, a repeated first marker into an empty good frame,
      // then a saturated oversize length, all under the reset register values.
      send_timed(8'h00, 1'b0);
      send_timed(8'hFF, 1'b0);
      send_timed(SYNC_FIRST, 1'b0);
      send_frame(VERSION_RESET, 8'd0, 8'd0, 1'b0, -1, 1'b0);
      send_frame(VERSION_RESET, 8'hFF, 8'd0, 1'b0, -1, 1'b1);
      wait_idle();

      // Random phases; the first few sequences walk every kind once.
      for (int p = 0; p < 3; p++) begin
         set_config(PHASE_TIMEOUT[p], PHASE_VERSION[p]);
         send_idle_pct = PHASE_SEND_IDLE[p];
         recv_idle_pct = PHASE_RECV_IDLE[p];
         while (bytes_sent < 24 + 40 * (p + 1)) begin
            run_sequence((seq_total < SEQ_COUNT) ? stim_kind_t'(seq_total) : pick_kind());
            seq_total++;
         end
         if (p == 2) begin
            // one frame at the largest payload
            resync();
            send_frame(cur_version, 8'(MAX_PAYLOAD_T), 8'd0, 1'b0, -1, 1'b0);
         end
         wait_idle();
      end

      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sfp_pkg.sv
rtl/core/sfp_front.sv
rtl/core/sfp_queue.sv
rtl/core/sfp_back.sv
rtl/core/serial_frame_parser.sv
rtl/core/sfp_checker.sv
test/serial_frame_parser_checker.sv
test/serial_frame_parser_test.sv
